// File: design/aavr_pkg.sv
// ----------------------------------------------------------------------------
// aavr_pkg : shared types and constants for the axis-angle rotation core
// Beat payload structs, Q30 angle constants and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package aavr_pkg;

   localparam int DATA_WIDTH       = 32;
   localparam int ANGLE_BITS       = 20;
   localparam int DEF_FRAC_BITS    = 16;
   localparam int DEF_CORDIC_STEPS = 16;
   localparam int ATAN_COUNT       = 24;

   localparam logic [63:0] PI_Q30      = 64'd3373259426;
   localparam logic [63:0] HALF_PI_Q30 = 64'd1686629713;
   localparam logic [63:0] TWO_PI_Q30  = 64'd6746518852;
   localparam logic [63:0] ONE_Q30     = 64'd1073741824;

   // atan(2^-i) in Q30
   localparam logic [31:0] ATAN_Q30 [ATAN_COUNT] = '{
      32'd843314857, 32'd497837829, 32'd263043837, 32'd133525159,
      32'd67021687,  32'd33543516,  32'd16775851,  32'd8388437,
      32'd4194283,   32'd2097149,   32'd1048576,   32'd524288,
      32'd262144,    32'd131072,    32'd65536,     32'd32768,
      32'd16384,     32'd8192,      32'd4096,      32'd2048,
      32'd1024,      32'd512,       32'd256,       32'd128
   };

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] vec_x;
      logic signed [DATA_WIDTH-1:0] vec_y;
      logic signed [DATA_WIDTH-1:0] vec_z;
      logic signed [DATA_WIDTH-1:0] axis_x;
      logic signed [DATA_WIDTH-1:0] axis_y;
      logic signed [DATA_WIDTH-1:0] axis_z;
      logic signed [ANGLE_BITS-1:0] rot_angle;
   } req_type;

   typedef struct packed {
      logic signed [DATA_WIDTH-1:0] out_x;
      logic signed [DATA_WIDTH-1:0] out_y;
      logic signed [DATA_WIDTH-1:0] out_z;
      logic                         axis_zero;
      logic                         saturated;
   } rsp_type;

endpackage

// File: design/axis_angle_vector_rotation_core.sv
// Stages: QM = max(50 - FRAC_BITS, 33) - 32 angle-reduction steps, the CORDIC
//   stages, a 32-step square-root pipe and a FRAC_BITS+1 step divider pipe.
// Throughput: one beat per cycle; busy is held low, the pipe never stalls.
// Reset: synchronous, clears only the valid pipe; data registers run free.
// The receiver cannot stall: each result is shown for exactly one cycle.
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_core : Rodrigues rotation, fully pipelined
// Normalizes the axis (sqrt + divide), makes cos/sin by CORDIC with gain
// removal, then rotates the vector and saturates to 32 bits.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_core
   import aavr_pkg::*;
#(
   parameter int FRAC_BITS    = DEF_FRAC_BITS,
   parameter int CORDIC_STEPS = DEF_CORDIC_STEPS
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_item,
   output logic    rsp_valid,
   output rsp_type rsp_item
);

   // ------------------------------------------------------------------------
   // Derived sizes
   // ------------------------------------------------------------------------
   localparam int F   = FRAC_BITS;
   localparam int NS  = (CORDIC_STEPS < ATAN_COUNT) ? CORDIC_STEPS : ATAN_COUNT;
   localparam int ZW  = 50 - F;                  // |angle| in Q30, bits
   localparam int MW  = (ZW > 33) ? ZW : 33;     // reduction register width
   localparam int QM  = MW - 32;                 // 2*pi subtract steps
   localparam int ZS  = 36;                      // folded angle, signed
   localparam int XW  = 34;                      // CORDIC x/y, signed
   localparam int AF  = QM + NS + 5;             // front end depth
   localparam int DL  = AF - 4;                  // axis delay to line up
   localparam int QB  = F + 1;                   // quotient bits
   localparam int DW  = 34 + F;                  // divider remainder width
   localparam int KW  = F + 2;                   // unit axis / cos / sin
   localparam int RW  = 40;                      // rotation arithmetic
   localparam int PW  = KW + DATA_WIDTH;         // k*v product
   localparam int MPW = KW + RW;                 // wide product
   localparam int LAT = AF + 32 + 1 + QB + 1 + 6;

   localparam logic signed [ZS-1:0] PI_S   = ZS'(PI_Q30);
   localparam logic signed [ZS-1:0] HPI_S  = ZS'(HALF_PI_Q30);
   localparam logic signed [ZS-1:0] TWO_S  = ZS'(TWO_PI_Q30);
   localparam logic signed [RW-1:0] HI_LIM = RW'(64'sh7FFF_FFFF);
   localparam logic signed [RW-1:0] LO_LIM = -HI_LIM - RW'(1);

   typedef struct packed {
      logic [2:0][DATA_WIDTH-1:0] v;
      logic [2:0]                 an;
      logic [2:0][DATA_WIDTH-1:0] am;
      logic                       az;
   } ac_type;

   typedef struct packed {
      logic [2:0][DATA_WIDTH-1:0] v;
      logic [2:0]                 an;
      logic [2:0][29:0]           asc;
      logic                       az;
      logic signed [XW-1:0]       cx;
      logic signed [XW-1:0]       cy;
   } pc_type;

   assign busy = 1'b0;

   // ------------------------------------------------------------------------
   // Valid pipe: one bit per register stage, the only reset state
   // ------------------------------------------------------------------------
   logic [LAT-1:0] vld_ff;
   logic [LAT-1:0] vld_in;
   assign vld_in = {vld_ff[LAT-2:0], start & ~busy};

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= vld_in;
      end
   end

   assign rsp_valid = vld_ff[LAT-1];

   // ------------------------------------------------------------------------
   // Angle path: Q30 conversion, C-style remainder by 2*pi
   // ------------------------------------------------------------------------
   logic [MW-1:0] zm_ff [QM+1];
   logic          zn_ff [QM+1];
   logic signed [MW:0] za_in;

   always_comb begin
      za_in = (MW+1)'(req_item.rot_angle);
      za_in = za_in <<< (30 - F);
   end

   always_ff @(posedge clock) begin
      zm_ff[0] <= za_in[MW] ? MW'(-za_in) : za_in[MW-1:0];
      zn_ff[0] <= za_in[MW];
   end

   // restoring remainder on the magnitude, sign reapplied at the fold
   for (genvar g = 0; g < QM; g++) begin : g_mod
      localparam logic [63:0] TP  = TWO_PI_Q30 << (QM - 1 - g);
      localparam logic [MW:0] TPW = TP[MW:0];
      always_ff @(posedge clock) begin
         if ({1'b0, zm_ff[g]} >= TPW) begin
            zm_ff[g+1] <= zm_ff[g] - TPW[MW-1:0];
         end else begin
            zm_ff[g+1] <= zm_ff[g];
         end
         zn_ff[g+1] <= zn_ff[g];
      end
   end

   // fold into [-pi/2, pi/2]; flip marks a negated CORDIC result
   logic signed [XW-1:0] xc_ff [NS+1];
   logic signed [XW-1:0] yc_ff [NS+1];
   logic signed [ZS-1:0] zc_ff [NS+1];
   logic                 fl_ff [NS+1];
   logic signed [ZS-1:0] zu_in, z1_in, z2_in;
   logic                 fl_in;

   always_comb begin
      zu_in = signed'(ZS'(zm_ff[QM]));
      if (zn_ff[QM]) begin
         zu_in = -zu_in;
      end
      if (zu_in > PI_S) begin
         z1_in = zu_in - TWO_S;
      end else if (zu_in < -PI_S) begin
         z1_in = zu_in + TWO_S;
      end else begin
         z1_in = zu_in;
      end
      fl_in = 1'b1;
      if (z1_in > HPI_S) begin
         z2_in = z1_in - PI_S;
      end else if (z1_in < -HPI_S) begin
         z2_in = z1_in + PI_S;
      end else begin
         z2_in = z1_in;
         fl_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      xc_ff[0] <= XW'(ONE_Q30);
      yc_ff[0] <= '0;
      zc_ff[0] <= z2_in;
      fl_ff[0] <= fl_in;
   end

   // CORDIC rotation, one micro-rotation per stage
   for (genvar g = 0; g < NS; g++) begin : g_cordic
      localparam logic signed [ZS-1:0] AT = ZS'(ATAN_Q30[g]);
      always_ff @(posedge clock) begin
         if (!zc_ff[g][ZS-1]) begin
            xc_ff[g+1] <= xc_ff[g] - (yc_ff[g] >>> g);
            yc_ff[g+1] <= yc_ff[g] + (xc_ff[g] >>> g);
            zc_ff[g+1] <= zc_ff[g] - AT;
         end else begin
            xc_ff[g+1] <= xc_ff[g] + (yc_ff[g] >>> g);
            yc_ff[g+1] <= yc_ff[g] - (xc_ff[g] >>> g);
            zc_ff[g+1] <= zc_ff[g] + AT;
         end
         fl_ff[g+1] <= fl_ff[g];
      end
   end

   // flip and square: x^2 and y^2 for gain removal, summed at the root pipe input
   logic signed [XW-1:0]   xf_ff, yf_ff, xq_ff, yq_ff;
   logic signed [2*XW-1:0] xs_ff, ys_ff;

   always_ff @(posedge clock) begin
      xf_ff <= fl_ff[NS] ? -xc_ff[NS] : xc_ff[NS];
      yf_ff <= fl_ff[NS] ? -yc_ff[NS] : yc_ff[NS];
      xs_ff <= xf_ff * xf_ff;
      ys_ff <= yf_ff * yf_ff;
      xq_ff <= xf_ff;
      yq_ff <= yf_ff;
   end

   // ------------------------------------------------------------------------
   // Axis path: delayed to meet the angle path at the sqrt pipe
   // ------------------------------------------------------------------------
   req_type rq_ff [DL];

   always_ff @(posedge clock) begin
      rq_ff[0] <= req_item;
   end

   for (genvar g = 1; g < DL; g++) begin : g_dly
      always_ff @(posedge clock) begin
         rq_ff[g] <= rq_ff[g-1];
      end
   end

   // X0: magnitudes and largest
   ac_type                ax0_ff, ax1_ff;
   logic [DATA_WIDTH-1:0] amax_ff;
   ac_type                ax0_in;
   logic [DATA_WIDTH-1:0] amax_in;

   always_comb begin
      ax0_in.v  = {rq_ff[DL-1].vec_z, rq_ff[DL-1].vec_y, rq_ff[DL-1].vec_x};
      ax0_in.an = {rq_ff[DL-1].axis_z[DATA_WIDTH-1], rq_ff[DL-1].axis_y[DATA_WIDTH-1],
                   rq_ff[DL-1].axis_x[DATA_WIDTH-1]};
      ax0_in.am[0] = ax0_in.an[0] ? DATA_WIDTH'(-rq_ff[DL-1].axis_x) : rq_ff[DL-1].axis_x;
      ax0_in.am[1] = ax0_in.an[1] ? DATA_WIDTH'(-rq_ff[DL-1].axis_y) : rq_ff[DL-1].axis_y;
      ax0_in.am[2] = ax0_in.an[2] ? DATA_WIDTH'(-rq_ff[DL-1].axis_z) : rq_ff[DL-1].axis_z;
      amax_in = ax0_in.am[0];
      if (ax0_in.am[1] > amax_in) begin
         amax_in = ax0_in.am[1];
      end
      if (ax0_in.am[2] > amax_in) begin
         amax_in = ax0_in.am[2];
      end
      // zero axis: every magnitude is zero
      ax0_in.az = (amax_in == '0);
   end

   always_ff @(posedge clock) begin
      ax0_ff  <= ax0_in;
      amax_ff <= amax_in;
   end

   // X1: bit length, then scale so the largest lands in [2^29, 2^30)
   logic [5:0]            bl_in;
   logic [2:0][29:0]      sc_in;
   logic [2:0][29:0]      sc_ff, sc2_ff;
   logic [DATA_WIDTH-1:0] sh_in;

   always_comb begin
      bl_in = '0;
      for (int i = 0; i < DATA_WIDTH; i++) begin
         if (amax_ff[i]) begin
            bl_in = 6'(i + 1);
         end
      end
      for (int i = 0; i < 3; i++) begin
         if (bl_in > 6'd30) begin
            sh_in = ax0_ff.am[i] >> (bl_in - 6'd30);
         end else begin
            sh_in = ax0_ff.am[i] << (6'd30 - bl_in);
         end
         sc_in[i] = sh_in[29:0];
      end
   end

   always_ff @(posedge clock) begin
      ax1_ff <= ax0_ff;
      sc_ff  <= sc_in;
   end

   // X2: squares
   ac_type           ax2_ff;
   logic [2:0][59:0] asq_ff;

   always_ff @(posedge clock) begin
      ax2_ff <= ax1_ff;
      sc2_ff <= sc_ff;
      for (int i = 0; i < 3; i++) begin
         asq_ff[i] <= sc_ff[i] * sc_ff[i];
      end
   end

   // ------------------------------------------------------------------------
   // Square root: two lanes, 2 radicand bits per stage
   //   lane 0 = axis sum of squares, lane 1 = CORDIC x^2 + y^2
   // ------------------------------------------------------------------------
   logic [1:0][63:0] sqv_ff [33];
   logic [1:0][34:0] sqr_ff [33];
   logic [1:0][31:0] sqt_ff [33];
   pc_type           pc_ff  [33];

   // X3 / gain sum stage feeds stage 0 of the root pipe
   always_ff @(posedge clock) begin
      sqv_ff[0][0] <= 64'(asq_ff[0]) + 64'(asq_ff[1]) + 64'(asq_ff[2]);
      sqv_ff[0][1] <= 64'(xs_ff) + 64'(ys_ff);
      sqr_ff[0]    <= '0;
      sqt_ff[0]    <= '0;
      pc_ff[0].v   <= ax2_ff.v;
      pc_ff[0].an  <= ax2_ff.an;
      pc_ff[0].asc <= sc2_ff;
      pc_ff[0].az  <= ax2_ff.az;
      pc_ff[0].cx  <= xq_ff;
      pc_ff[0].cy  <= yq_ff;
   end

   for (genvar s = 0; s < 32; s++) begin : g_sqrt
      logic [1:0][34:0] rm_in;
      logic [1:0][34:0] tr_in;
      always_comb begin
         for (int l = 0; l < 2; l++) begin
            rm_in[l] = {sqr_ff[s][l][32:0], sqv_ff[s][l][63:62]};
            tr_in[l] = {1'b0, sqt_ff[s][l], 2'b01};
         end
      end
      always_ff @(posedge clock) begin
         for (int l = 0; l < 2; l++) begin
            sqv_ff[s+1][l] <= sqv_ff[s][l] << 2;
            if (rm_in[l] >= tr_in[l]) begin
               sqr_ff[s+1][l] <= rm_in[l] - tr_in[l];
               sqt_ff[s+1][l] <= {sqt_ff[s][l][30:0], 1'b1};
            end else begin
               sqr_ff[s+1][l] <= rm_in[l];
               sqt_ff[s+1][l] <= {sqt_ff[s][l][30:0], 1'b0};
            end
         end
         pc_ff[s+1] <= pc_ff[s];
      end
   end

   // ------------------------------------------------------------------------
   // Divider: five lanes, one quotient bit per stage
   //   lanes 0..2: |a_i| << F / norm, lanes 3..4: |x|,|y| << F / gain
   // ------------------------------------------------------------------------
   logic [4:0][DW-1:0] dr_ff [QB+1];
   logic [4:0][QB-1:0] dq_ff [QB+1];
   logic [31:0]        dn_ff [QB+1];
   logic [31:0]        dg_ff [QB+1];
   pc_type             pd_ff [QB+1];
   logic [XW-1:0]      mx_in, my_in;

   always_comb begin
      mx_in = pc_ff[32].cx[XW-1] ? XW'(-pc_ff[32].cx) : pc_ff[32].cx;
      my_in = pc_ff[32].cy[XW-1] ? XW'(-pc_ff[32].cy) : pc_ff[32].cy;
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         dr_ff[0][i] <= DW'(pc_ff[32].asc[i]) << F;
      end
      dr_ff[0][3] <= DW'(mx_in) << F;
      dr_ff[0][4] <= DW'(my_in) << F;
      dq_ff[0]    <= '0;
      dn_ff[0]    <= sqt_ff[32][0];
      dg_ff[0]    <= (sqt_ff[32][1] == '0) ? 32'd1 : sqt_ff[32][1];
      pd_ff[0]    <= pc_ff[32];
   end

   for (genvar d = 0; d < QB; d++) begin : g_div
      localparam int SH = QB - 1 - d;
      logic [4:0][DW-1:0] ds_in;
      always_comb begin
         for (int l = 0; l < 5; l++) begin
            ds_in[l] = (l < 3) ? (DW'(dn_ff[d]) << SH) : (DW'(dg_ff[d]) << SH);
         end
      end
      always_ff @(posedge clock) begin
         for (int l = 0; l < 5; l++) begin
            if (dr_ff[d][l] >= ds_in[l]) begin
               dr_ff[d+1][l] <= dr_ff[d][l] - ds_in[l];
               dq_ff[d+1][l] <= dq_ff[d][l] | (QB'(1) << SH);
            end else begin
               dr_ff[d+1][l] <= dr_ff[d][l];
               dq_ff[d+1][l] <= dq_ff[d][l];
            end
         end
         dn_ff[d+1] <= dn_ff[d];
         dg_ff[d+1] <= dg_ff[d];
         pd_ff[d+1] <= pd_ff[d];
      end
   end

   // sign stage: unit axis k, cos, sin (truncated toward zero)
   logic signed [KW-1:0]         k_ff [3];
   logic signed [KW-1:0]         cs_ff, sn_ff;
   logic signed [DATA_WIDTH-1:0] v_ff [3];
   logic                         az_ff;
   logic [4:0]                   sg_in;

   assign sg_in = {pd_ff[QB].cy[XW-1], pd_ff[QB].cx[XW-1], pd_ff[QB].an};

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         k_ff[i] <= sg_in[i] ? -signed'({1'b0, dq_ff[QB][i]}) : signed'({1'b0, dq_ff[QB][i]});
         v_ff[i] <= signed'(pd_ff[QB].v[i]);
      end
      cs_ff <= sg_in[3] ? -signed'({1'b0, dq_ff[QB][3]}) : signed'({1'b0, dq_ff[QB][3]});
      sn_ff <= sg_in[4] ? -signed'({1'b0, dq_ff[QB][4]}) : signed'({1'b0, dq_ff[QB][4]});
      az_ff <= pd_ff[QB].az;
   end

   // ------------------------------------------------------------------------
   // Rotation: out = (v - p)*cos + (k x v)*sin + p, p = (k.v)k
   // every product is exact, then shifted right by F (floor)
   // ------------------------------------------------------------------------
   // P1: k.v terms and cross product terms
   logic signed [PW-1:0]         pd1_ff [3];
   logic signed [PW-1:0]         pc1_ff [6];
   logic signed [KW-1:0]         k1_ff [3];
   logic signed [KW-1:0]         cs1_ff, sn1_ff;
   logic signed [DATA_WIDTH-1:0] v1_ff [3];
   logic                         az1_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pd1_ff[i] <= k_ff[i] * v_ff[i];
      end
      pc1_ff[0] <= k_ff[1] * v_ff[2];
      pc1_ff[1] <= k_ff[2] * v_ff[1];
      pc1_ff[2] <= k_ff[2] * v_ff[0];
      pc1_ff[3] <= k_ff[0] * v_ff[2];
      pc1_ff[4] <= k_ff[0] * v_ff[1];
      pc1_ff[5] <= k_ff[1] * v_ff[0];
      k1_ff  <= k_ff;
      v1_ff  <= v_ff;
      cs1_ff <= cs_ff;
      sn1_ff <= sn_ff;
      az1_ff <= az_ff;
   end

   // P2: dot and cross
   logic signed [RW-1:0]         dot2_ff;
   logic signed [RW-1:0]         c2_ff [3];
   logic signed [KW-1:0]         k2_ff [3];
   logic signed [KW-1:0]         cs2_ff, sn2_ff;
   logic signed [DATA_WIDTH-1:0] v2_ff [3];
   logic                         az2_ff;
   logic signed [RW-1:0]         t2_in [9];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         t2_in[i] = RW'(pd1_ff[i] >>> F);
      end
      for (int i = 0; i < 6; i++) begin
         t2_in[3+i] = RW'(pc1_ff[i] >>> F);
      end
   end

   always_ff @(posedge clock) begin
      dot2_ff  <= t2_in[0] + t2_in[1] + t2_in[2];
      c2_ff[0] <= t2_in[3] - t2_in[4];
      c2_ff[1] <= t2_in[5] - t2_in[6];
      c2_ff[2] <= t2_in[7] - t2_in[8];
      k2_ff    <= k1_ff;
      v2_ff    <= v1_ff;
      cs2_ff   <= cs1_ff;
      sn2_ff   <= sn1_ff;
      az2_ff   <= az1_ff;
   end

   // P3: along-axis products dot*k
   logic signed [MPW-1:0]        pp3_ff [3];
   logic signed [RW-1:0]         c3_ff [3];
   logic signed [KW-1:0]         cs3_ff, sn3_ff;
   logic signed [DATA_WIDTH-1:0] v3_ff [3];
   logic                         az3_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         pp3_ff[i] <= dot2_ff * k2_ff[i];
      end
      c3_ff  <= c2_ff;
      v3_ff  <= v2_ff;
      cs3_ff <= cs2_ff;
      sn3_ff <= sn2_ff;
      az3_ff <= az2_ff;
   end

   // P4: p and the perpendicular part n
   logic signed [RW-1:0]         p4_ff [3];
   logic signed [RW-1:0]         n4_ff [3];
   logic signed [RW-1:0]         c4_ff [3];
   logic signed [KW-1:0]         cs4_ff, sn4_ff;
   logic signed [DATA_WIDTH-1:0] v4_ff [3];
   logic                         az4_ff;
   logic signed [RW-1:0]         p4_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         p4_in[i] = RW'(pp3_ff[i] >>> F);
      end
   end

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         p4_ff[i] <= p4_in[i];
         n4_ff[i] <= RW'(v3_ff[i]) - p4_in[i];
      end
      c4_ff  <= c3_ff;
      v4_ff  <= v3_ff;
      cs4_ff <= cs3_ff;
      sn4_ff <= sn3_ff;
      az4_ff <= az3_ff;
   end

   // P5: n*cos and c*sin
   logic signed [MPW-1:0]        nc5_ff [3];
   logic signed [MPW-1:0]        cs5_ff [3];
   logic signed [RW-1:0]         p5_ff [3];
   logic signed [DATA_WIDTH-1:0] v5_ff [3];
   logic                         az5_ff;

   always_ff @(posedge clock) begin
      for (int i = 0; i < 3; i++) begin
         nc5_ff[i] <= n4_ff[i] * cs4_ff;
         cs5_ff[i] <= c4_ff[i] * sn4_ff;
      end
      p5_ff  <= p4_ff;
      v5_ff  <= v4_ff;
      az5_ff <= az4_ff;
   end

   // P6: sum, clamp, zero-axis pass-through, output register
   logic signed [RW-1:0]         r6_in [3];
   logic signed [DATA_WIDTH-1:0] o6_in [3];
   logic [2:0]                   st6_in;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         r6_in[i]  = RW'(nc5_ff[i] >>> F) + RW'(cs5_ff[i] >>> F) + p5_ff[i];
         st6_in[i] = 1'b1;
         if (r6_in[i] > HI_LIM) begin
            o6_in[i] = HI_LIM[DATA_WIDTH-1:0];
         end else if (r6_in[i] < LO_LIM) begin
            o6_in[i] = LO_LIM[DATA_WIDTH-1:0];
         end else begin
            o6_in[i]  = r6_in[i][DATA_WIDTH-1:0];
            st6_in[i] = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (az5_ff) begin
         rsp_item.out_x     <= v5_ff[0];
         rsp_item.out_y     <= v5_ff[1];
         rsp_item.out_z     <= v5_ff[2];
         rsp_item.axis_zero <= 1'b1;
         rsp_item.saturated <= 1'b0;
      end else begin
         rsp_item.out_x     <= o6_in[0];
         rsp_item.out_y     <= o6_in[1];
         rsp_item.out_z     <= o6_in[2];
         rsp_item.axis_zero <= 1'b0;
         rsp_item.saturated <= |st6_in;
      end
   end

   // ------------------------------------------------------------------------
   // Assertions
   // ------------------------------------------------------------------------
   localparam logic signed [DATA_WIDTH-1:0] OUT_MAX = HI_LIM[DATA_WIDTH-1:0];
   localparam logic signed [DATA_WIDTH-1:0] OUT_MIN = LO_LIM[DATA_WIDTH-1:0];

   // every accepted beat raises rsp_valid when it leaves the valid pipe
   a_lat_hit: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##LAT rsp_valid)
      else $error("accepted beat did not reach the output on time");

   a_lat_miss: assert property (@(posedge clock) disable iff (reset)
      !(start && !busy) |-> ##LAT !rsp_valid)
      else $error("result strobe without an accepted beat");

   // zero axis passes the vector through untouched
   a_zero_pass: assert property (@(posedge clock) disable iff (reset)
      (start && !busy && req_item.axis_x == '0 && req_item.axis_y == '0 &&
       req_item.axis_z == '0) |-> ##LAT (rsp_valid && rsp_item.axis_zero &&
       !rsp_item.saturated && rsp_item.out_x == $past(req_item.vec_x, LAT) &&
       rsp_item.out_y == $past(req_item.vec_y, LAT) &&
       rsp_item.out_z == $past(req_item.vec_z, LAT)))
      else $error("zero axis beat not passed through");

   // a clamp flag means some component sits on a rail
   a_sat_rail: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.saturated) |->
      (rsp_item.out_x == OUT_MAX || rsp_item.out_x == OUT_MIN ||
       rsp_item.out_y == OUT_MAX || rsp_item.out_y == OUT_MIN ||
       rsp_item.out_z == OUT_MAX || rsp_item.out_z == OUT_MIN))
      else $error("saturated set with no clamped component");

endmodule

// File: tb/axis_angle_vector_rotation_core_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// axis_angle_vector_rotation_core_tb : self-checking bench for the rotation core
// Directed corner beats, then about 1600 random rotations in three sender
// idle modes. Every accepted beat is predicted bit for bit; results are
// checked in order. A watchdog ends a stuck run.
// ----------------------------------------------------------------------------
module axis_angle_vector_rotation_core_tb;
   import aavr_pkg::*;

   localparam int FRAC     = 16;
   localparam int STEPS    = 16;
   localparam int LATENCY  = 80;
   localparam int WD_LIMIT = 4000;     // idle cycles with no beat either way
   localparam int N_RANDOM = 1600;

   // Rotation predictor plus the queue of rotations still owed by the core.
   class rotation_scoreboard;
      rsp_type owed_q[$];
      int      mismatches;
      int      n_noted;
      int      n_checked;
      int      n_zero_axis;
      int      n_sat;

      function automatic longint mag(longint v);
         return (v < 0) ? -v : v;
      endfunction

      function automatic bit [63:0] isqrt(bit [63:0] v);
         bit [63:0] root, bt;
         root = 0;
         bt = 64'd1 << 62;
         while (bt > v) bt >>= 2;
         while (bt != 0) begin
            if (v >= root + bt) begin
               v -= root + bt;
               root = (root >> 1) + bt;
            end else begin
               root >>= 1;
            end
            bt >>= 2;
         end
         return root;
      endfunction

      // Q product: exact wide product, arithmetic shift, clamp to 64 bits
      function automatic longint qmul(longint a, longint b);
         logic signed [127:0] wa, wb, p;
         wa = a;
         wb = b;
         p = (wa * wb) >>> FRAC;
         if (p[127:63] != '0 && p[127:63] != '1)
            return p[127] ? 64'sh8000000000000000 : 64'sh7fffffffffffffff;
         return p[63:0];
      endfunction

      function automatic void cos_sin(longint ang, output longint cs, output longint sn);
         longint pi_q, half_pi, z, x, y, dx, dy, at, gl;
         bit [63:0] ax, ay;
         bit flip;
         pi_q = PI_Q30;
         half_pi = HALF_PI_Q30;
         z = ang * (64'sd1 << (30 - FRAC));
         x = ONE_Q30;
         y = 0;
         flip = 0;
         z = z % (2 * pi_q);
         if (z > pi_q) z -= 2 * pi_q;
         if (z < -pi_q) z += 2 * pi_q;
         if (z > half_pi) begin
            z -= pi_q;
            flip = 1;
         end else if (z < -half_pi) begin
            z += pi_q;
            flip = 1;
         end
         for (int i = 0; i < STEPS; i++) begin
            dx = y >>> i;
            dy = x >>> i;
            at = ATAN_Q30[i];
            if (z >= 0) begin
               x -= dx; y += dy; z -= at;
            end else begin
               x += dx; y -= dy; z += at;
            end
         end
         if (flip) begin
            x = -x;
            y = -y;
         end
         ax = mag(x);
         ay = mag(y);
         gl = isqrt(ax * ax + ay * ay);
         if (gl == 0) gl = 1;
         cs = (x * (64'sd1 << FRAC)) / gl;
         sn = (y * (64'sd1 << FRAC)) / gl;
      endfunction

      function automatic rsp_type rotate(req_type it);
         rsp_type   r;
         longint    v[3], a[3], k[3], c[3], p[3], res[3];
         longint    cs, sn, dot, nrm;
         bit [63:0] m, mg, sumsq;
         int        nbits;
         v[0] = it.vec_x;  v[1] = it.vec_y;  v[2] = it.vec_z;
         a[0] = it.axis_x; a[1] = it.axis_y; a[2] = it.axis_z;
         r = '0;
         m = 0;
         for (int i = 0; i < 3; i++) if (mag(a[i]) > m) m = mag(a[i]);
         if (m == 0) begin
            // zero axis: vector passes straight through
            r.out_x = it.vec_x;
            r.out_y = it.vec_y;
            r.out_z = it.vec_z;
            r.axis_zero = 1'b1;
            return r;
         end
         nbits = 0;
         for (bit [63:0] t = m; t != 0; t >>= 1) nbits++;
         sumsq = 0;
         for (int i = 0; i < 3; i++) begin
            mg = mag(a[i]);
            mg = (nbits > 30) ? (mg >> (nbits - 30)) : (mg << (30 - nbits));
            a[i] = (a[i] < 0) ? -longint'(mg) : longint'(mg);
            sumsq += mg * mg;
         end
         nrm = isqrt(sumsq);
         if (nrm == 0) nrm = 1;
         for (int i = 0; i < 3; i++) k[i] = (a[i] * (64'sd1 << FRAC)) / nrm;
         cos_sin(longint'(it.rot_angle), cs, sn);
         dot = qmul(k[0], v[0]) + qmul(k[1], v[1]) + qmul(k[2], v[2]);
         c[0] = qmul(k[1], v[2]) - qmul(k[2], v[1]);
         c[1] = qmul(k[2], v[0]) - qmul(k[0], v[2]);
         c[2] = qmul(k[0], v[1]) - qmul(k[1], v[0]);
         for (int i = 0; i < 3; i++) begin
            p[i] = qmul(dot, k[i]);
            res[i] = qmul(v[i] - p[i], cs) + qmul(c[i], sn) + p[i];
            if (res[i] > 64'sd2147483647) begin
               res[i] = 64'sd2147483647;
               r.saturated = 1'b1;
            end
            if (res[i] < -64'sd2147483648) begin
               res[i] = -64'sd2147483648;
               r.saturated = 1'b1;
            end
         end
         r.out_x = res[0][31:0];
         r.out_y = res[1][31:0];
         r.out_z = res[2][31:0];
         return r;
      endfunction

      function void note_beat(req_type it);
         rsp_type r;
         r = rotate(it);
         n_noted++;
         if (r.axis_zero) n_zero_axis++;
         if (r.saturated) n_sat++;
         owed_q.push_back(r);
      endfunction

      function void check_beat(rsp_type got);
         rsp_type exp_r;
         n_checked++;
         if (owed_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: unexpected result beat %p", got);
            return;
         end
         exp_r = owed_q.pop_front();
         if (got.out_x !== exp_r.out_x || got.out_y !== exp_r.out_y ||
             got.out_z !== exp_r.out_z || got.axis_zero !== exp_r.axis_zero ||
             got.saturated !== exp_r.saturated) begin
            mismatches++;
            if (mismatches <= 10)
               $display("ERROR: result %0d exp x=%h y=%h z=%h zero=%b sat=%b",
                        n_checked, exp_r.out_x, exp_r.out_y, exp_r.out_z,
                        exp_r.axis_zero, exp_r.saturated,
                        " got x=%h y=%h z=%h zero=%b sat=%b",
                        got.out_x, got.out_y, got.out_z, got.axis_zero,
                        got.saturated);
         end
      endfunction
   endclass

   logic    clock;
   logic    reset;
   logic    start;
   logic    busy;
   req_type req_item;
   logic    rsp_valid;
   rsp_type rsp_item;

   rotation_scoreboard sb;
   int idle_pct;
   int quiet_cycles;

   axis_angle_vector_rotation_core #(
      .FRAC_BITS    (FRAC),
      .CORDIC_STEPS (STEPS)
   ) dut (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .req_item  (req_item),
      .rsp_valid (rsp_valid),
      .rsp_item  (rsp_item)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // result side: the core cannot be stalled, so every strobe is a beat
   always @(posedge clock) begin
      if (!reset && rsp_valid) sb.check_beat(rsp_item);
   end

   // watchdog: counts cycles where no beat moves in either direction
   always @(posedge clock) begin
      if ((start && !busy) || (!reset && rsp_valid)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WD_LIMIT) begin
            $display("watchdog expired, %0d results outstanding", sb.owed_q.size());
            $display("status: fail");
            $finish;
         end
      end
   end

   // one input beat; optional idle gap first, then start is held high until the beat is taken
   task automatic send_beat(req_type it);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      req_item <= it;
      start    <= 1'b1;
      do @(posedge clock); while (busy);
      sb.note_beat(it);
   endtask

   task automatic drain();
      start <= 1'b0;
      while (sb.owed_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [31:0] rand_comp(bit wide);
      int unsigned span;
      if (wide) return $urandom;
      span = 32'd1 << $urandom_range(24, 4);
      return $signed($urandom_range(2 * span, 0)) - $signed(span);
   endfunction

   function automatic req_type rand_beat();
      req_type it;
      bit wide;
      int sel;
      wide = ($urandom_range(3) == 0);
      it.vec_x = rand_comp(wide);
      it.vec_y = rand_comp(wide);
      it.vec_z = rand_comp(wide);
      sel = $urandom_range(99);
      if (sel < 5) begin
         it.axis_x = 0; it.axis_y = 0; it.axis_z = 0;
      end else if (sel < 15) begin
         // single-component axis, sometimes tiny
         it.axis_x = 0; it.axis_y = 0; it.axis_z = 0;
         case ($urandom_range(2))
            0: it.axis_x = $urandom_range(1) ? $urandom : $urandom_range(7);
            1: it.axis_y = $urandom_range(1) ? $urandom : $urandom_range(7);
            default: it.axis_z = $urandom_range(1) ? $urandom : $urandom_range(7);
         endcase
      end else if (sel < 60) begin
         it.axis_x = $urandom;
         it.axis_y = $urandom;
         it.axis_z = $urandom;
      end else begin
         it.axis_x = rand_comp(1'b0);
         it.axis_y = rand_comp(1'b0);
         it.axis_z = rand_comp(1'b0);
      end
      if ($urandom_range(4) == 0) it.rot_angle = 20'($urandom);
      else it.rot_angle = 20'($signed($urandom_range(823550, 0)) - 411775);
      return it;
   endfunction

   function automatic req_type mk(logic signed [31:0] vx, logic signed [31:0] vy,
                                  logic signed [31:0] vz, logic signed [31:0] ax,
                                  logic signed [31:0] ay, logic signed [31:0] az,
                                  logic signed [19:0] ang);
      req_type it;
      it.vec_x = vx; it.vec_y = vy; it.vec_z = vz;
      it.axis_x = ax; it.axis_y = ay; it.axis_z = az;
      it.rot_angle = ang;
      return it;
   endfunction

   initial begin
      localparam logic signed [31:0] ONE  = 32'sh00010000;
      localparam logic signed [31:0] MAXV = 32'sh7fffffff;
      localparam logic signed [31:0] MINV = 32'sh80000000;
      localparam logic signed [19:0] QPI  = 20'sd51472;    // pi/4
      localparam logic signed [19:0] PI   = 20'sd205887;
      sb = new();
      idle_pct = 0;
      quiet_cycles = 0;
      reset = 1'b1;
      start = 1'b0;
      req_item = '0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;

      // directed corners
      send_beat(mk(ONE, 2 * ONE, 3 * ONE, 0, 0, 0, QPI));           // zero axis
      send_beat(mk(MAXV, MINV, -1, 0, 0, 0, 20'sh7ffff));           // zero axis, extremes
      send_beat(mk(ONE, 0, 0, 0, 0, ONE, 20'sd102944));             // 90 deg about z
      send_beat(mk(ONE, ONE, ONE, ONE, 0, 0, 0));                   // zero angle
      send_beat(mk(ONE, 0, 0, 0, 0, ONE, PI));                      // pi
      send_beat(mk(ONE, 0, 0, 0, 0, ONE, -PI));                     // -pi
      send_beat(mk(ONE, 0, 0, 0, ONE, 0, 20'sd411775));             // two pi
      send_beat(mk(0, ONE, 0, ONE, 0, 0, -20'sd411775));            // minus two pi
      send_beat(mk(ONE, ONE, 0, 0, 0, ONE, 20'sh7ffff));            // angle wraps
      send_beat(mk(ONE, ONE, 0, 0, 0, ONE, 20'sh80000));            // angle wraps
      send_beat(mk(MAXV, MAXV, 0, 0, 0, ONE, QPI));                 // saturates
      send_beat(mk(MINV, MINV, MINV, 0, 0, -ONE, -QPI));            // saturates
      send_beat(mk(MAXV, MINV, MAXV, MINV, MINV, MINV, QPI));       // largest axis
      send_beat(mk(ONE, 2 * ONE, -ONE, MAXV, 0, MINV, 20'sd70000));
      send_beat(mk(ONE, 2 * ONE, 3 * ONE, 1, 0, 0, QPI));           // tiny axis
      send_beat(mk(ONE, 2 * ONE, 3 * ONE, -1, 1, -1, PI));
      send_beat(mk(ONE, 2 * ONE, 3 * ONE, 0, 1, 0, -20'sd150000));
      send_beat(mk(3 * ONE, -ONE, ONE, ONE, ONE, ONE, 20'sd137258)); // 120 deg diag
      send_beat(mk(-1, 1, 0, 0, 0, MAXV, 20'sd1));
      send_beat(mk(0, 0, 0, ONE, 2 * ONE, 3 * ONE, QPI));           // zero vector

      // hold off until the pipe is empty before the random part
      drain();

      for (int n = 0; n < N_RANDOM; n++) begin
         // bursts can step n past a phase boundary, so test by range
         if (n >= N_RANDOM / 3 && idle_pct == 29) begin
            drain();
            idle_pct = 86;
         end else if (n >= 2 * N_RANDOM / 3 && idle_pct == 86) begin
            idle_pct = 0;
         end else if (n == 0) begin
            idle_pct = 29;
         end
         // bursts of eight extra beats inside the idle phases; each still takes its idle gap
         if (idle_pct != 0 && $urandom_range(19) == 0) begin
            for (int b = 0; b < 8; b++) begin
               send_beat(rand_beat());
               n++;
            end
         end
         send_beat(rand_beat());
      end
      start <= 1'b0;

      while (sb.owed_q.size() != 0) @(posedge clock);
      repeat (LATENCY + 20) @(posedge clock);

      $display("covered %0d rotations checked, %0d with zero axis, %0d saturated",
               sb.n_checked, sb.n_zero_axis, sb.n_sat);
      $display("%0d mismatches, %0d results outstanding", sb.mismatches, sb.owed_q.size());
      if (sb.mismatches == 0 && sb.owed_q.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
